[hw/rtl/rgbcfb_pkg.sv]
// Package for the RGB555 colour map and frame blend unit.
// Holds the transaction payload types, register codes and colour constants.
// No dependencies.
`default_nettype none

package rgbcfb_pkg;

	typedef struct packed {
		logic [14:0] pixel_color;
		logic [15:0] pixel_offset;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_t;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register word index, taken from paddr[2].
	localparam logic REG_COLOR_CORRECT = 1'b0;
	localparam logic REG_FRAME_BLEND   = 1'b1;

	localparam logic [7:0] CAP_LEVEL = 8'd240;

	localparam logic [9:0] COEF_RR = 10'd26;
	localparam logic [9:0] COEF_RG = 10'd4;
	localparam logic [9:0] COEF_RB = 10'd2;
	localparam logic [9:0] COEF_GG = 10'd24;
	localparam logic [9:0] COEF_GB = 10'd8;
	localparam logic [9:0] COEF_BR = 10'd6;
	localparam logic [9:0] COEF_BG = 10'd4;
	localparam logic [9:0] COEF_BB = 10'd22;

endpackage

`default_nettype wire

[hw/rtl/rgb555_color_map_frame_blend_unit.sv]
// RGB555 to RGB888 colour mapper with optional blending against the previous frame.
// An accepted pixel goes through stage 1 and the result register to a valid result.
// Throughput: one pixel per cycle unless rgb_stall holds the output; the frame store
// takes one read and one write a cycle. After reset the frame store is cleared one
// entry a cycle, all FRAME_PIXELS entries, with pixel_stall held high; configuration
// writes are taken throughout. Depends on rgbcfb_pkg, rgbcfb_ram and rgbcfb_convert.
`default_nettype none

module rgb555_color_map_frame_blend_unit #(
	parameter int FRAME_PIXELS = 61440
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    psel,
	input  wire                                    penable,
	input  wire                                    pwrite,
	input  wire  [rgbcfb_pkg::CFG_ADDR_W-1:0]      paddr,
	input  wire  [rgbcfb_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [rgbcfb_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                   pready,
	input  wire                                    pixel_valid,
	output logic                                   pixel_stall,
	input  wire rgbcfb_pkg::pixel_t                pixel,
	output logic                                   rgb_valid,
	input  wire                                    rgb_stall,
	output rgbcfb_pkg::rgb_t                       rgb
);

	localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
	localparam int EXT_W  = (ADDR_W + 1 > 16) ? ADDR_W + 1 : 16;

	logic              color_correct_q;
	logic              frame_blend_q;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              valid_s1;
	logic [14:0]       color_s1;
	logic              in_range_s1;

	logic              rgb_valid_q;
	rgbcfb_pkg::rgb_t  rgb_q;

	logic              accept;
	logic              s1_adv;
	logic [EXT_W-1:0]  offset_ext;
	logic [ADDR_W-1:0] offset_addr;
	logic              in_range;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [14:0]       ram_wdata;
	logic [14:0]       ram_rdata;
	logic [14:0]       prev_color;
	rgbcfb_pkg::rgb_t  cur_rgb;
	rgbcfb_pkg::rgb_t  prev_rgb;
	rgbcfb_pkg::rgb_t  blend_rgb;
	logic [8:0]        sum_r;
	logic [8:0]        sum_g;
	logic [8:0]        sum_b;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_correct_q <= 1'b0;
			frame_blend_q   <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				rgbcfb_pkg::REG_COLOR_CORRECT: color_correct_q <= pwdata[0];
				rgbcfb_pkg::REG_FRAME_BLEND:   frame_blend_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			rgbcfb_pkg::REG_COLOR_CORRECT: prdata[0] = color_correct_q;
			rgbcfb_pkg::REG_FRAME_BLEND:   prdata[0] = frame_blend_q;
			default: ;
		endcase
	end

	// Frame store clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(FRAME_PIXELS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// Handshake.
	assign s1_adv      = valid_s1 && (!rgb_valid_q || !rgb_stall);
	assign pixel_stall = clearing_q || (valid_s1 && !s1_adv);
	assign accept      = pixel_valid && !pixel_stall;

	assign offset_ext  = EXT_W'(pixel.pixel_offset);
	assign offset_addr = offset_ext[ADDR_W-1:0];
	assign in_range    = offset_ext < EXT_W'(FRAME_PIXELS);

	assign ram_we    = clearing_q || (accept && in_range);
	assign ram_waddr = clearing_q ? clr_addr_q : offset_addr;
	assign ram_wdata = clearing_q ? 15'd0 : pixel.pixel_color;

	rgbcfb_ram #(
		.WIDTH (15),
		.DEPTH (FRAME_PIXELS)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (offset_addr),
		.rdata (ram_rdata)
	);

	// Stage 1: pixel held while the previous colour is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			color_s1    <= pixel.pixel_color;
			in_range_s1 <= in_range;
		end
	end

	assign prev_color = in_range_s1 ? ram_rdata : 15'd0;

	rgbcfb_convert u_cur_convert (
		.color   (color_s1),
		.correct (color_correct_q),
		.rgb     (cur_rgb)
	);

	rgbcfb_convert u_prev_convert (
		.color   (prev_color),
		.correct (color_correct_q),
		.rgb     (prev_rgb)
	);

	assign sum_r = {1'b0, cur_rgb.red_out}   + {1'b0, prev_rgb.red_out};
	assign sum_g = {1'b0, cur_rgb.green_out} + {1'b0, prev_rgb.green_out};
	assign sum_b = {1'b0, cur_rgb.blue_out}  + {1'b0, prev_rgb.blue_out};

	always_comb begin
		if (frame_blend_q) begin
			blend_rgb.red_out   = sum_r[8:1];
			blend_rgb.green_out = sum_g[8:1];
			blend_rgb.blue_out  = sum_b[8:1];
		end else begin
			blend_rgb = cur_rgb;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rgb_valid_q <= 1'b1;
		end else if (!rgb_stall) begin
			rgb_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rgb_q <= blend_rgb;
		end
	end

	assign rgb_valid = rgb_valid_q;
	assign rgb       = rgb_q;

endmodule

`default_nettype wire

[hw/rtl/rgbcfb_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and write to the same address in one cycle returns the old data.
// No dependencies.
`default_nettype none

module rgbcfb_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 61440
) (
	input  wire                                           clk,
	input  wire                                           we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    waddr,
	input  wire  [WIDTH-1:0]                              wdata,
	input  wire                                           re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/rgbcfb_convert.sv]
// Converts one RGB555 colour to 8-bit R, G, B channels, either by bit
// replication or through the handheld correction matrix capped at 240.
// Depends on rgbcfb_pkg.
`default_nettype none

module rgbcfb_convert (
	input  wire  [14:0]             color,
	input  wire                     correct,
	output rgbcfb_pkg::rgb_t        rgb
);

	logic [4:0] r;
	logic [4:0] g;
	logic [4:0] b;
	logic [9:0] sum_r;
	logic [9:0] sum_g;
	logic [9:0] sum_b;
	logic [7:0] mix_r;
	logic [7:0] mix_g;
	logic [7:0] mix_b;

	assign r = color[4:0];
	assign g = color[9:5];
	assign b = color[14:10];

	assign sum_r = 10'(r) * rgbcfb_pkg::COEF_RR + 10'(g) * rgbcfb_pkg::COEF_RG
		+ 10'(b) * rgbcfb_pkg::COEF_RB;
	assign sum_g = 10'(g) * rgbcfb_pkg::COEF_GG + 10'(b) * rgbcfb_pkg::COEF_GB;
	assign sum_b = 10'(r) * rgbcfb_pkg::COEF_BR + 10'(g) * rgbcfb_pkg::COEF_BG
		+ 10'(b) * rgbcfb_pkg::COEF_BB;

	assign mix_r = (sum_r[9:2] > rgbcfb_pkg::CAP_LEVEL) ? rgbcfb_pkg::CAP_LEVEL : sum_r[9:2];
	assign mix_g = (sum_g[9:2] > rgbcfb_pkg::CAP_LEVEL) ? rgbcfb_pkg::CAP_LEVEL : sum_g[9:2];
	assign mix_b = (sum_b[9:2] > rgbcfb_pkg::CAP_LEVEL) ? rgbcfb_pkg::CAP_LEVEL : sum_b[9:2];

	always_comb begin
		if (correct) begin
			rgb.red_out   = mix_r;
			rgb.green_out = mix_g;
			rgb.blue_out  = mix_b;
		end else begin
			rgb.red_out   = {r, r[4:2]};
			rgb.green_out = {g, g[4:2]};
			rgb.blue_out  = {b, b[4:2]};
		end
	end

endmodule

`default_nettype wire
